// ===== hdl/pup_pkg.sv =====
// shared types, constants and the fire palette for the 2x palette upscaler
// no dependencies; imported by every module of the block but pup_ram
`timescale 1ns / 1ps

package pup_pkg;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned REG_W   = 12;
   localparam int unsigned INDEX_W = 2;

   localparam logic [REG_W-1:0] HEIGHT_LIMIT      = 12'd2048;
   localparam logic [REG_W-1:0] HALF_WIDTH_RESET  = 12'd640;
   localparam logic [REG_W-1:0] HALF_HEIGHT_RESET = 12'd360;

   localparam logic [INDEX_W-1:0] REG_HALF_WIDTH  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_HALF_HEIGHT = 2'd1;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_type;

   // one 2x2 output block: palette indices in emit order and top-left coordinate
   typedef struct packed {
      logic [3:0][LEVEL_W-1:0] idx;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
   } blk_type;

   // fire ramp: dark red, red, red to yellow, yellow to white, fade to grey
   function automatic rgb_type pup_palette(input logic [LEVEL_W-1:0] v);
      rgb_type            c;
      logic [LEVEL_W-1:0] d;
      logic [LEVEL_W-1:0] i;
      c = '0;
      d = '0;
      i = v - 8'd204;
      if (v < 8'd16) begin
         c.red = v;
      end else if (v < 8'd76) begin
         d = v - 8'd12;
         c.red = {d[5:0], 2'b00};
      end else if (v < 8'd140) begin
         d = v - 8'd76;
         c.red   = 8'd255;
         c.green = {d[5:0], 2'b00};
      end else if (v < 8'd204) begin
         d = v - 8'd140;
         c.red   = 8'd255;
         c.green = 8'd255;
         c.blue  = {d[5:0], 2'b00};
      end else begin
         c.red   = 8'd255 - (i + i + i);
         c.green = 8'd255 - (i + i);
         c.blue  = 8'd255 - (i + i);
      end
      return c;
   endfunction

endpackage

// ===== hdl/pup_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// read-first on a same-address collision; no dependencies
`timescale 1ns / 1ps

module pup_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2049
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/pup_line_ctrl.sv =====
// source cell intake: frame counters, line store read-modify-write and the
// neighbour stage that forms the four palette indices; uses pup_pkg, pup_ram
`timescale 1ns / 1ps

module pup_line_ctrl #(
   parameter int unsigned MAX_HALF_WIDTH = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pup_pkg::LEVEL_W-1:0]     req_level,
   input  logic                            req_start_of_frame,
   input  logic [pup_pkg::REG_W-1:0]       half_width,
   input  logic [pup_pkg::REG_W-1:0]       half_height,
   output logic                            blk_valid,
   input  logic                            blk_ready,
   output pup_pkg::blk_type                blk
);

   import pup_pkg::*;

   localparam int unsigned CW    = $clog2(MAX_HALF_WIDTH + 1);
   localparam int unsigned DEPTH = MAX_HALF_WIDTH + 1;

   logic [CW-1:0]      column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [LEVEL_W-1:0] left_ff, left_in;
   logic               pend_wr_ff, pend_wr_in;
   logic [CW-1:0]      pend_addr_ff, pend_addr_in;
   logic [LEVEL_W-1:0] pend_data_ff, pend_data_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_emit_ff, s1_emit_in;
   logic [LEVEL_W-1:0] s1_v3_ff, s1_v3_in;
   logic [LEVEL_W-1:0] s1_v4_ff, s1_v4_in;
   logic [COORD_W-1:0] s1_x_ff, s1_x_in;
   logic [COORD_W-1:0] s1_y_ff, s1_y_in;
   logic [LEVEL_W-1:0] prev_v2_ff, prev_v2_in;

   logic               accept;
   logic               s1_adv;
   logic               s1_free;
   logic [CW-1:0]      c;
   logic [COORD_W-1:0] r;
   logic [12:0]        hw_wide;
   logic [CW-1:0]      hw;
   logic [COORD_W-1:0] hh;
   logic               row_end;

   logic               ram_we;
   logic [CW-1:0]      ram_waddr;
   logic [LEVEL_W-1:0] ram_wdata;
   logic               ram_re;
   logic [CW-1:0]      ram_raddr;
   logic [LEVEL_W-1:0] ram_rdata;

   logic [LEVEL_W:0]   sum_right;
   logic [LEVEL_W:0]   sum_lower;
   logic [LEVEL_W+1:0] sum_all;

   pup_ram #(
      .WIDTH(LEVEL_W),
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // the stage only moves on when its block can be handed over or it holds no block to emit
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || blk_ready);
   assign s1_free   = !s1_valid_ff || s1_adv;
   // an end-of-row write waits in the pending register and holds off new transfers while it has the write port
   assign req_ready = s1_free && !pend_wr_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hw_wide = (13'(half_width) > 13'(MAX_HALF_WIDTH)) ? 13'(MAX_HALF_WIDTH)
                                                         : 13'(half_width);
      hw      = CW'(hw_wide);
      hh      = (half_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : half_height;
      c       = req_start_of_frame ? '0 : column_ff;
      r       = req_start_of_frame ? '0 : row_ff;
      row_end = (c >= hw);
   end

   // line store: read the entry above, write the previous cell one column behind
   always_comb begin
      ram_re    = accept;
      ram_raddr = c;
      ram_we    = pend_wr_ff || (accept && (c != '0));
      ram_waddr = pend_wr_ff ? pend_addr_ff : (c - CW'(1));
      ram_wdata = pend_wr_ff ? pend_data_ff : left_ff;
   end

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      left_in      = left_ff;
      pend_wr_in   = 1'b0;
      pend_addr_in = c;
      pend_data_in = req_level;
      if (accept) begin
         left_in    = req_level;
         pend_wr_in = row_end;
         if (row_end) begin
            column_in = '0;
            row_in    = (r >= hh) ? '0 : (r + 12'd1);
         end else begin
            column_in = c + CW'(1);
            row_in    = r;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_emit_in  = s1_emit_ff;
      s1_v3_in    = s1_v3_ff;
      s1_v4_in    = s1_v4_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      prev_v2_in  = prev_v2_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
         prev_v2_in  = ram_rdata;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_emit_in  = (r != '0) && (c != '0);
         s1_v3_in    = left_ff;
         s1_v4_in    = req_level;
         s1_x_in     = 12'({c - CW'(1), 1'b0});
         s1_y_in     = 12'({r - 12'd1, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         pend_wr_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         pend_wr_ff  <= pend_wr_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      s1_emit_ff   <= s1_emit_in;
      s1_v3_ff     <= s1_v3_in;
      s1_v4_ff     <= s1_v4_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      prev_v2_ff   <= prev_v2_in;
   end

   // upper-left is the entry read for the previous column, upper-right is fresh
   always_comb begin
      sum_right  = {1'b0, prev_v2_ff} + {1'b0, ram_rdata};
      sum_lower  = {1'b0, prev_v2_ff} + {1'b0, s1_v3_ff};
      sum_all    = {2'b00, prev_v2_ff} + {2'b00, ram_rdata}
                 + {2'b00, s1_v3_ff} + {2'b00, s1_v4_ff};
      blk.idx[0] = prev_v2_ff;
      blk.idx[1] = sum_right[LEVEL_W:1];
      blk.idx[2] = sum_lower[LEVEL_W:1];
      blk.idx[3] = sum_all[LEVEL_W+1:2];
      blk.x      = s1_x_ff;
      blk.y      = s1_y_ff;
      blk_valid  = s1_valid_ff && s1_emit_ff;
   end

   a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("line store read and write collide on one entry");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      column_ff <= CW'(MAX_HALF_WIDTH))
      else $error("column counter beyond the line store");

   a_end_write_stalls: assert property (@(posedge clock) disable iff (reset)
      (accept && row_end) |=> (pend_wr_ff && !accept))
      else $error("end-of-row write overlapped by a new transfer");

endmodule

// ===== hdl/pup_emit.sv =====
// output sequencer: holds one 2x2 block and sends its four pixels through the
// palette into the registered result port; uses pup_pkg
`timescale 1ns / 1ps

module pup_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        blk_valid,
   output logic                        blk_ready,
   input  pup_pkg::blk_type            blk,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_red,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_green,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_blue,
   output logic [pup_pkg::COORD_W-1:0] rsp_out_x,
   output logic [pup_pkg::COORD_W-1:0] rsp_out_y,
   output logic                        rsp_last_of_run
);

   import pup_pkg::*;

   logic               b_valid_ff, b_valid_in;
   blk_type            b_ff, b_in;
   logic [1:0]         beat_ff, beat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rgb_type            rgb_ff, rgb_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic               last_ff, last_in;

   logic               o_load;
   logic               b_take;
   logic               b_done;

   assign o_load    = !rsp_valid_ff || rsp_ready;
   assign b_take    = b_valid_ff && o_load;
   assign b_done    = b_take && (beat_ff == 2'd3);
   assign blk_ready = !b_valid_ff || b_done;

   always_comb begin
      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      beat_in    = beat_ff;
      if (b_take) begin
         beat_in = beat_ff + 2'd1;
      end
      if (b_done) begin
         b_valid_in = 1'b0;
      end
      if (blk_valid && blk_ready) begin
         b_valid_in = 1'b1;
         b_in       = blk;
         beat_in    = 2'd0;
      end
   end

   // beat bit 0 steps right, bit 1 steps down
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rgb_in       = rgb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      if (o_load) begin
         rsp_valid_in = b_valid_ff;
         rgb_in       = pup_palette(b_ff.idx[beat_ff]);
         x_in         = b_ff.x | {{(COORD_W-1){1'b0}}, beat_ff[0]};
         y_in         = b_ff.y | {{(COORD_W-1){1'b0}}, beat_ff[1]};
         last_in      = (beat_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         beat_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      rgb_ff  <= rgb_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rgb_ff.red;
   assign rsp_green       = rgb_ff.green;
   assign rsp_blue        = rgb_ff.blue;
   assign rsp_out_x       = x_ff;
   assign rsp_out_y       = y_ff;
   assign rsp_last_of_run = last_ff;

   a_beat_needs_block: assert property (@(posedge clock) disable iff (reset)
      (beat_ff != 2'd0) |-> b_valid_ff)
      else $error("beat counter running without a block");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (x_ff[0] && y_ff[0]))
      else $error("last pixel of a block not at its lower-right corner");

endmodule

// ===== hdl/palette_upscale_2x_interpolate.sv =====
// pipeline: neighbour stage, block register, result register; a block's first pixel
//   follows the cell that completes it, the other three one per cycle while rsp_ready is high
// throughput: one output pixel per cycle while rsp_ready is high; a cell that ends a row
//   also holds the line store write port in the cycle after its transfer
// reset: counters, pipeline and result port cleared, half_width 640,
//   half_height 360; the line store is not cleared
`timescale 1ns / 1ps

module palette_upscale_2x_interpolate #(
   parameter int unsigned MAX_HALF_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pup_pkg::LEVEL_W-1:0] req_level,
   input  logic                        req_start_of_frame,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_red,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_green,
   output logic [pup_pkg::LEVEL_W-1:0] rsp_blue,
   output logic [pup_pkg::COORD_W-1:0] rsp_out_x,
   output logic [pup_pkg::COORD_W-1:0] rsp_out_y,
   output logic                        rsp_last_of_run,
   input  logic                        csr_we,
   input  logic [pup_pkg::INDEX_W-1:0] csr_index,
   input  logic [pup_pkg::REG_W-1:0]   csr_wdata
);

   import pup_pkg::*;

   logic [REG_W-1:0] half_width_ff, half_width_in;
   logic [REG_W-1:0] half_height_ff, half_height_in;
   logic             blk_valid;
   logic             blk_ready;
   blk_type          blk;

   always_comb begin
      half_width_in  = half_width_ff;
      half_height_in = half_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_HALF_WIDTH:  half_width_in  = csr_wdata;
            REG_HALF_HEIGHT: half_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_WIDTH_RESET;
         half_height_ff <= HALF_HEIGHT_RESET;
      end else begin
         half_width_ff  <= half_width_in;
         half_height_ff <= half_height_in;
      end
   end

   pup_line_ctrl #(
      .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
   ) u_line_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_level         (req_level),
      .req_start_of_frame(req_start_of_frame),
      .half_width        (half_width_ff),
      .half_height       (half_height_ff),
      .blk_valid         (blk_valid),
      .blk_ready         (blk_ready),
      .blk               (blk)
   );

   pup_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .blk_valid      (blk_valid),
      .blk_ready      (blk_ready),
      .blk            (blk),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

// ===== verif/upscale_checker.sv =====
// checker for the 2x palette upscaler: watches the cell, pixel and register ports,
// predicts every pixel and compares it field by field with what the block sends
// depends on pup_pkg for widths, register indexes and reset values
`timescale 1ns / 1ps

module upscale_checker #(
   parameter int unsigned MAX_HALF_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [pup_pkg::LEVEL_W-1:0] req_level,
   input  logic                        req_start_of_frame,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [pup_pkg::LEVEL_W-1:0] rsp_red,
   input  logic [pup_pkg::LEVEL_W-1:0] rsp_green,
   input  logic [pup_pkg::LEVEL_W-1:0] rsp_blue,
   input  logic [pup_pkg::COORD_W-1:0] rsp_out_x,
   input  logic [pup_pkg::COORD_W-1:0] rsp_out_y,
   input  logic                        rsp_last_of_run,
   input  logic                        csr_we,
   input  logic [pup_pkg::INDEX_W-1:0] csr_index,
   input  logic [pup_pkg::REG_W-1:0]   csr_wdata,
   output int                          pixels_owed,
   output int                          mismatches
);
   import pup_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last_of_run;
   } screen_pixel_type;

   screen_pixel_type   pending_pixels [$];
   screen_pixel_type   seen;
   screen_pixel_type   want;
   logic [REG_W-1:0]   width_reg;
   logic [REG_W-1:0]   height_reg;
   logic [LEVEL_W-1:0] row_above [0:MAX_HALF_WIDTH];
   logic [LEVEL_W-1:0] left_level;
   int unsigned        col_count;
   int unsigned        row_count;
   int unsigned        hw;
   int unsigned        hh;
   int unsigned        c;
   int unsigned        r;
   int unsigned        upper_left;
   int unsigned        upper_right;
   int unsigned        lower_left;
   int unsigned        px;
   int unsigned        py;
   int                 fail_count;

   // fire ramp lookup plus screen position of one output pixel
   function automatic screen_pixel_type shade(input int unsigned idx, input int unsigned sx,
                                              input int unsigned sy, input logic closing);
      screen_pixel_type p;
      int unsigned      rd;
      int unsigned      gn;
      int unsigned      bl;
      if (idx < 16) begin
         rd = idx;
         gn = 0;
         bl = 0;
      end else if (idx < 76) begin
         rd = 4 * (idx - 12);
         gn = 0;
         bl = 0;
      end else if (idx < 140) begin
         rd = 255;
         gn = 4 * (idx - 76);
         bl = 0;
      end else if (idx < 204) begin
         rd = 255;
         gn = 255;
         bl = 4 * (idx - 140);
      end else begin
         rd = 255 - 3 * (idx - 204);
         gn = 255 - 2 * (idx - 204);
         bl = gn;
      end
      p.red         = 8'(rd);
      p.green       = 8'(gn);
      p.blue        = 8'(bl);
      p.x           = 12'(sx);
      p.y           = 12'(sy);
      p.last_of_run = closing;
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_pixels.delete();
         width_reg  = HALF_WIDTH_RESET;
         height_reg = HALF_HEIGHT_RESET;
         left_level = '0;
         col_count  = 0;
         row_count  = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_red, rsp_green, rsp_blue, rsp_out_x, rsp_out_y, rsp_last_of_run};
            if (pending_pixels.size() == 0) begin
               fail_count++;
               $error("pixel transfer with nothing pending: x %0d y %0d", rsp_out_x,
                      rsp_out_y);
            end else begin
               want = pending_pixels.pop_front();
               if (seen != want) begin
                  fail_count++;
                  if (seen.red != want.red)
                     $error("red: expected %0d, got %0d", want.red, seen.red);
                  if (seen.green != want.green)
                     $error("green: expected %0d, got %0d", want.green, seen.green);
                  if (seen.blue != want.blue)
                     $error("blue: expected %0d, got %0d", want.blue, seen.blue);
                  if (seen.x != want.x)
                     $error("out_x: expected %0d, got %0d", want.x, seen.x);
                  if (seen.y != want.y)
                     $error("out_y: expected %0d, got %0d", want.y, seen.y);
                  if (seen.last_of_run != want.last_of_run)
                     $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                            seen.last_of_run);
               end
            end
         end

         if (csr_we) begin
            if (csr_index == REG_HALF_WIDTH)
               width_reg = csr_wdata;
            else if (csr_index == REG_HALF_HEIGHT)
               height_reg = csr_wdata;
         end

         if (req_valid && req_ready) begin
            hw = (width_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : width_reg;
            hh = (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
            if (req_start_of_frame) begin
               col_count = 0;
               row_count = 0;
            end
            c = (col_count > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : col_count;
            r = row_count;

            // this cell is the lower right corner of the block whose top left is (r-1,c-1)
            if (r > 0 && c > 0) begin
               upper_left  = row_above[c-1];
               upper_right = row_above[c];
               lower_left  = left_level;
               px = 2 * (c - 1);
               py = 2 * (r - 1);
               pending_pixels.push_back(shade(upper_left, px, py, 1'b0));
               pending_pixels.push_back(shade((upper_left + upper_right) / 2, px + 1, py,
                                              1'b0));
               pending_pixels.push_back(shade((upper_left + lower_left) / 2, px, py + 1,
                                              1'b0));
               pending_pixels.push_back(shade((upper_left + upper_right + lower_left
                                               + req_level) / 4, px + 1, py + 1, 1'b1));
            end

            // the row store trails one column behind, the row end catches up
            if (c > 0)
               row_above[c-1] = left_level;
            if (c >= hw) begin
               row_above[c] = req_level;
               col_count = 0;
               row_count = (r >= hh) ? 0 : r + 1;
            end else begin
               col_count = c + 1;
               row_count = r;
            end
            left_level = req_level;
         end
      end
      pixels_owed <= pending_pixels.size();
      mismatches  <= fail_count;
   end

endmodule

// ===== verif/testbench.sv =====
// top of the 2x palette upscaler testbench: clock, reset, cell and register stimulus,
// pixel back-pressure, watchdog and verdict
// depends on pup_pkg, palette_upscale_2x_interpolate and upscale_checker
`timescale 1ns / 1ps

module testbench;
   import pup_pkg::*;

   localparam int unsigned MAX_HALF_WIDTH  = 2048;
   localparam int          QUIET_LIMIT     = 3000;
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          HOLD_OFF_CYCLES = 400;

   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW, RX_SHUT} drain_mode_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic [LEVEL_W-1:0] req_level          = '0;
   logic               req_start_of_frame = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic [LEVEL_W-1:0] rsp_red;
   logic [LEVEL_W-1:0] rsp_green;
   logic [LEVEL_W-1:0] rsp_blue;
   logic [COORD_W-1:0] rsp_out_x;
   logic [COORD_W-1:0] rsp_out_y;
   logic               rsp_last_of_run;
   logic               csr_we             = 1'b0;
   logic [INDEX_W-1:0] csr_index          = '0;
   logic [REG_W-1:0]   csr_wdata          = '0;

   int                 pixels_owed;
   int                 mismatches;
   int                 burst_left         = 0;
   logic               hold_off_asked     = 1'b0;
   logic               held_off;
   drain_mode_type     rx_mode;
   int                 seg_left;
   int unsigned        rx_pick;
   int                 quiet_cycles;

   // two 3x3 frames: palette band edges first, then extremes for the averages
   logic [LEVEL_W-1:0] corner_levels [18] = '{
      8'd0,   8'd255, 8'd15,  8'd16,  8'd75,  8'd76,  8'd139, 8'd140, 8'd203,
      8'd204, 8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd12,  8'd200, 8'd1
   };

   always #2 clock = ~clock;

   palette_upscale_2x_interpolate #(
      .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_level          (req_level),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   upscale_checker #(
      .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
   ) pixel_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_level          (req_level),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pixels_owed        (pixels_owed),
      .mismatches         (mismatches)
   );

   // offers one cell and returns at the edge of its transfer; bursts with random gaps
   task automatic send_cell(input logic [LEVEL_W-1:0] level, input logic sof);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_level          <= level;
      req_start_of_frame <= sof;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_cells(input int count, input bit open_frame, input bit restarts);
      logic [LEVEL_W-1:0] lvl;
      logic               sof;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 7))
            0:       lvl = '0;
            1:       lvl = '1;
            default: lvl = 8'($urandom_range(0, 255));
         endcase
         if (i == 0)
            sof = open_frame;
         else
            sof = restarts && ($urandom_range(0, 39) == 0);
         send_cell(lvl, sof);
      end
   endtask

   // wait until every predicted pixel is out and the pipeline has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= REG_HALF_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= REG_HALF_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // pixel side back-pressure: segments of open, choppy, slow and shut
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_mode   <= RX_OPEN;
         seg_left  <= 0;
         held_off  <= 1'b0;
      end else if (hold_off_asked && !held_off) begin
         held_off  <= 1'b1;
         rx_mode   <= RX_SHUT;
         seg_left  <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (seg_left == 0) begin
         rx_pick = $urandom_range(0, 9);
         if (rx_pick < 4)
            rx_mode <= RX_OPEN;
         else if (rx_pick < 7)
            rx_mode <= RX_CHOPPY;
         else if (rx_pick < 9)
            rx_mode <= RX_SLOW;
         else
            rx_mode <= RX_SHUT;
         seg_left  <= $urandom_range(8, 120);
         rsp_ready <= 1'b1;
      end else begin
         seg_left <= seg_left - 1;
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:   rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x3 frame, then a second one that starts from the wrap alone
      set_geometry(12'd2, 12'd2);
      for (int i = 0; i < 18; i++)
         send_cell(corner_levels[i], i == 0);
      settle();

      // one-cell rows, then a one-row frame: no pixels from either
      set_geometry(12'd0, 12'd3);
      random_cells(3, 1'b1, 1'b0);
      settle();
      set_geometry(12'd3, 12'd0);
      random_cells(4, 1'b1, 1'b0);
      settle();

      // width shrinks part way through a frame
      set_geometry(12'd4, 12'd3);
      random_cells(12, 1'b1, 1'b0);
      settle();
      set_geometry(12'd2, 12'd3);
      random_cells(10, 1'b0, 1'b0);
      settle();

      // random frames; the first one never has a zero width or height and sees a long hold-off
      hold_off_asked <= 1'b1;
      for (int p = 0; p < 4; p++) begin
         set_geometry((p > 0 && $urandom_range(0, 9) == 0) ? 12'd0
                                                           : 12'($urandom_range(1, 6)),
                      (p > 0 && $urandom_range(0, 9) == 0) ? 12'd0
                                                           : 12'($urandom_range(1, 5)));
         random_cells(40, 1'b1, 1'b1);
         settle();
      end

      // oversized width: the start of a long first row
      set_geometry(12'd4095, 12'd2);
      random_cells(6, 1'b1, 1'b0);
      settle();

      // oversized height: a few three-cell rows
      set_geometry(12'd2, 12'd4095);
      random_cells(12, 1'b1, 1'b0);
      settle();

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pup_pkg.sv
hdl/pup_ram.sv
hdl/pup_line_ctrl.sv
hdl/pup_emit.sv
hdl/palette_upscale_2x_interpolate.sv
verif/upscale_checker.sv
verif/testbench.sv
